FILE: rtl/iapee_pkg.sv
// ----------------------------------------------------------------------------
// iapee_pkg
// Shared types and constants for the in-application programming controller.
// ----------------------------------------------------------------------------
`default_nettype none

package iapee_pkg;

   // Access kinds carried in the operation field.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register map.
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_COMMAND = 3'd1;
   localparam logic [2:0] REG_ADDR_HI = 3'd2;
   localparam logic [2:0] REG_ADDR_LO = 3'd3;
   localparam logic [2:0] REG_DATA    = 3'd4;
   localparam logic [2:0] REG_TRIGGER = 3'd5;

   // Command codes.
   localparam logic [1:0] CMD_IDLE    = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_PROGRAM = 2'd2;
   localparam logic [1:0] CMD_ERASE   = 2'd3;

   // Trigger key bytes and the erased value.
   localparam logic [7:0] TRIG_ARM  = 8'h5A;
   localparam logic [7:0] TRIG_FIRE = 8'hA5;
   localparam logic [7:0] ERASED    = 8'hFF;

   // Control register bits.
   localparam int CTRL_ENABLE_BIT = 7;
   localparam int CTRL_FAIL_BIT   = 4;

   // Address register width and the width used for address compares.
   localparam int ADDR_W = 16;
   localparam int CMP_W  = ADDR_W + 1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // a request beat is taken this cycle
      logic capture;    // load the data register from the store read port
      logic write_back; // write old AND data back to the store
      logic find_init;  // clear the sector search counter
      logic find;       // advance the sector search by one sector
      logic sweep;      // write the erased value and advance the sweep counter
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       go;          // the request beat starts a command that runs
      logic [1:0] cmd;         // latched command code
      logic       find_done;   // the search counter holds the sector base
      logic       sweep_done;  // the sweep counter is at its last entry
      logic       rsp_free;    // the response register can take a beat
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/iap_eeprom_controller_top.sv
// ----------------------------------------------------------------------------
// iap_eeprom_controller_top
// In-application programming controller for a byte-wide on-chip data store.
// ----------------------------------------------------------------------------
// Each request beat is one register access (read or write of control,
// command, address high, address low, data or trigger), and each produces
// exactly one response beat, loaded into the response register at the edge
// that accepts the request. Writing 0x5A and then 0xA5 to the trigger
// starts the latched command; the response to the firing beat carries the
// fail flag at once, and the command then runs while the request side is
// held off: a read or program holds it while the store's registered read
// port delivers the byte, and a sector erase holds it for a sector search
// that steps one sector at a time up to the address, and then for the
// erase of each byte of the sector (up to SECTOR_BYTES). After reset the
// store is swept to 0xFF one byte a cycle, so no request is accepted until
// every byte of the store has been swept. A request is also held off while
// the response register is full and not being taken.
`default_nettype none

module iap_eeprom_controller_top #(
   parameter int STORE_BYTES  = 1024,  // store size in bytes, 512 to 65536
   parameter int SECTOR_BYTES = 512    // erase sector size, 64 to 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] write_data
   input  wire logic [3:0] req_tuser,   // [0] operation, [3:1] reg_select
   // Response channel.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] read_data
   output logic [0:0]      rsp_tuser    // [0] op_failed
);

   iapee_pkg::dp_cmd_type    cmd;
   iapee_pkg::dp_status_type status;

   // The sequencer decides when a beat is taken and which command step runs.
   iapee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the registers, the store and the response register.
   iapee_dp #(
      .STORE_BYTES  (STORE_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: rtl/iapee_ram.sv
// ----------------------------------------------------------------------------
// iapee_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iapee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/iapee_ctrl.sv
// ----------------------------------------------------------------------------
// iapee_ctrl
// Sequencer for the controller: clearing pass, idle, and command execution.
// ----------------------------------------------------------------------------
`default_nettype none

module iapee_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire iapee_pkg::dp_status_type status,
   output iapee_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_PROG  = 3'd3;
   localparam logic [2:0] S_FIND  = 3'd4;
   localparam logic [2:0] S_ERASE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE) && status.rsp_free;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.accept    = req_tready && req_tvalid;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.accept && status.go) begin
               case (status.cmd)
                  iapee_pkg::CMD_READ:    state_in = S_READ;
                  iapee_pkg::CMD_PROGRAM: state_in = S_PROG;
                  iapee_pkg::CMD_ERASE: begin
                     state_in      = S_FIND;
                     cmd.find_init = 1'b1;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            cmd.capture = 1'b1;
            state_in    = S_IDLE;
         end
         S_PROG: begin
            cmd.write_back = 1'b1;
            state_in       = S_IDLE;
         end
         S_FIND: begin
            cmd.find = 1'b1;
            if (status.find_done) begin
               state_in = S_ERASE;
            end
         end
         S_ERASE: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/iapee_dp.sv
// ----------------------------------------------------------------------------
// iapee_dp
// Datapath: register file, trigger key, sector sweep counter, the data
// store and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module iapee_dp #(
   parameter int STORE_BYTES  = 1024,
   parameter int SECTOR_BYTES = 512
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire iapee_pkg::dp_cmd_type    cmd,
   output iapee_pkg::dp_status_type      status,
   input  wire logic [7:0]               req_tdata,
   input  wire logic [3:0]               req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic [0:0]                    rsp_tuser
);

   localparam int AW    = $clog2(STORE_BYTES);
   localparam int EW    = $clog2(STORE_BYTES + SECTOR_BYTES + 1);
   localparam int CMP_W = iapee_pkg::CMP_W;
   localparam logic [CMP_W-1:0] STORE_LIM  = CMP_W'(STORE_BYTES);
   localparam logic [CMP_W-1:0] SECTOR_LEN = CMP_W'(SECTOR_BYTES);

   logic                          op;
   logic [2:0]                    sel;
   logic [7:0]                    wd;

   logic [7:0]                    control_ff, control_in;
   logic [1:0]                    command_ff, command_in;
   logic [iapee_pkg::ADDR_W-1:0]  address_ff, address_in;
   logic [7:0]                    data_ff, data_in;
   logic                          armed_ff, armed_in;
   logic [EW-1:0]                 cnt_ff, cnt_in;
   logic [EW-1:0]                 last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_data_ff, rsp_data_in;
   logic                          rsp_fail_ff, rsp_fail_in;

   logic                          fire;
   logic                          fail;
   logic [CMP_W-1:0]              find_sum;
   logic [CMP_W-1:0]              sector_end;
   logic [7:0]                    rd_mux;
   logic [7:0]                    ram_q;
   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [7:0]                    ram_wdata;

   assign op  = req_tuser[0];
   assign sel = req_tuser[3:1];
   assign wd  = req_tdata;

   assign fire = (op == iapee_pkg::OP_WRITE) && (sel == iapee_pkg::REG_TRIGGER) &&
                 (wd == iapee_pkg::TRIG_FIRE) && armed_ff;
   assign fail = (command_ff != iapee_pkg::CMD_IDLE) &&
                 (!control_ff[iapee_pkg::CTRL_ENABLE_BIT] ||
                  ({1'b0, address_ff} >= STORE_LIM));

   assign find_sum   = CMP_W'(cnt_ff) + SECTOR_LEN;
   assign sector_end = (find_sum < STORE_LIM) ? find_sum : STORE_LIM;

   assign status.go         = fire && !fail && (command_ff != iapee_pkg::CMD_IDLE);
   assign status.cmd        = command_ff;
   assign status.find_done  = find_sum > {1'b0, address_ff};
   assign status.sweep_done = cnt_ff == last_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (sel)
         iapee_pkg::REG_CONTROL: rd_mux = control_ff;
         iapee_pkg::REG_COMMAND: rd_mux = {6'b0, command_ff};
         iapee_pkg::REG_ADDR_HI: rd_mux = address_ff[15:8];
         iapee_pkg::REG_ADDR_LO: rd_mux = address_ff[7:0];
         iapee_pkg::REG_DATA:    rd_mux = data_ff;
         default:                rd_mux = 8'h00;
      endcase
   end

   always_comb begin
      control_in   = control_ff;
      command_in   = command_ff;
      address_in   = address_ff;
      data_in      = data_ff;
      armed_in     = armed_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_fail_in  = rsp_fail_ff;

      if (cmd.accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = 8'h00;
         rsp_fail_in  = 1'b0;
         if (op == iapee_pkg::OP_READ) begin
            rsp_data_in = rd_mux;
         end else begin
            armed_in = 1'b0;
            case (sel)
               iapee_pkg::REG_CONTROL: control_in = wd;
               iapee_pkg::REG_COMMAND: command_in = wd[1:0];
               iapee_pkg::REG_ADDR_HI: address_in[15:8] = wd;
               iapee_pkg::REG_ADDR_LO: address_in[7:0]  = wd;
               iapee_pkg::REG_DATA:    data_in = wd;
               iapee_pkg::REG_TRIGGER: begin
                  if (wd == iapee_pkg::TRIG_ARM) begin
                     armed_in = 1'b1;
                  end else if (fire && fail) begin
                     control_in[iapee_pkg::CTRL_FAIL_BIT] = 1'b1;
                     rsp_fail_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end

      if (cmd.capture) begin
         data_in = ram_q;
      end

      if (cmd.find_init) begin
         cnt_in = '0;
      end

      if (cmd.find) begin
         if (status.find_done) begin
            last_in = EW'(sector_end - CMP_W'(1));
         end else begin
            cnt_in = EW'(find_sum);
         end
      end

      if (cmd.sweep && !status.sweep_done) begin
         cnt_in = cnt_ff + EW'(1);
      end
   end

   // The store port reads the addressed byte every cycle; a read or program
   // command uses the value in the cycle after the trigger beat.
   assign ram_we    = cmd.write_back || cmd.sweep;
   assign ram_waddr = cmd.write_back ? address_ff[AW-1:0] : cnt_ff[AW-1:0];
   assign ram_wdata = cmd.write_back ? (ram_q & data_ff) : iapee_pkg::ERASED;

   iapee_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (address_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= 8'h00;
         command_ff   <= iapee_pkg::CMD_IDLE;
         address_ff   <= '1;
         data_ff      <= iapee_pkg::ERASED;
         armed_ff     <= 1'b0;
         cnt_ff       <= '0;
         last_ff      <= EW'(STORE_BYTES - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         control_ff   <= control_in;
         command_ff   <= command_in;
         address_ff   <= address_in;
         data_ff      <= data_in;
         armed_ff     <= armed_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_fail_ff <= rsp_fail_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_fail_ff;

endmodule

`default_nettype wire

FILE: rtl/iapee_checker.sv
// ----------------------------------------------------------------------------
// iapee_checker
// Port-level checks for the in-application programming controller.
// ----------------------------------------------------------------------------
`default_nettype none

module iapee_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic [3:0] req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [0:0] rsp_tuser
);

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // Every accepted request is answered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response after accepted request");

   // A register write returns zero read data.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == iapee_pkg::OP_WRITE) |=> rsp_tdata == 8'h00)
      else $error("write returned nonzero read data");

   // Only a firing trigger write can report a failure.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      !((req_tuser[0] == iapee_pkg::OP_WRITE) &&
        (req_tuser[3:1] == iapee_pkg::REG_TRIGGER) &&
        (req_tdata == iapee_pkg::TRIG_FIRE))
      |=> !rsp_tuser[0])
      else $error("failure reported on a beat that fired nothing");

   // Right after reset the clearing pass holds off requests and responses.
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

endmodule

bind iap_eeprom_controller_top iapee_checker u_checker (.*);

`default_nettype wire
